### rtl/core/otsu_pkg.sv
// ---------------------------------------------------------------------------
// otsu_pkg
// Shared types and constants of the frame threshold block.
// ---------------------------------------------------------------------------
package otsu_pkg;

    localparam int NBINS   = 256;
    localparam int LVL_W   = 8;
    localparam int CNT_W   = 17;
    localparam int WB_W    = CNT_W + 1;
    localparam int SUM_W   = 24;
    localparam int DIFF_W  = 41;
    localparam int WT_W    = 32;
    localparam int LIMB_W  = 32;
    localparam int PROD_W  = 2 * LIMB_W;
    localparam int ACC_W   = 4 * LIMB_W;
    localparam int SQ_W    = 2 * DIFF_W;
    localparam int STEP_W  = 5;

    localparam logic [LVL_W-1:0] LAST_LVL = LVL_W'(NBINS - 1);

    typedef enum logic [2:0] {
        S_ACCUM,
        S_RD,
        S_BIN,
        S_CALC,
        S_EMIT
    } t_state;

    // one pixel as it travels from front to back
    typedef struct packed {
        logic [LVL_W-1:0] green;
        logic             last;
    } t_pix;

    // one partial product request to the shared multiplier
    typedef struct packed {
        logic              en;
        logic              clr;
        logic [1:0]        sh;
        logic [LIMB_W-1:0] a;
        logic [LIMB_W-1:0] b;
    } t_mac_op;

endpackage

### rtl/core/otsu_front.sv
// ---------------------------------------------------------------------------
// otsu_front
// Pixel intake: tags the frame's last pixel and holds up to two pixels in a
// small queue so the histogram side can stall on its own.
// ---------------------------------------------------------------------------
module otsu_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [otsu_pkg::LVL_W-1:0]   i_green_value,
    input  logic                         i_frame_end,
    output logic                         o_q_vld,
    output otsu_pkg::t_pix               o_q_item,
    input  logic                         i_pop
);
    import otsu_pkg::*;

    t_pix       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push;

    assign o_stall  = (r_cnt == 2'd2);
    assign push     = i_valid && !o_stall;
    assign o_q_vld  = (r_cnt != 2'd0);
    assign o_q_item = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= '{green: i_green_value, last: i_frame_end};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            case ({push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

### rtl/core/otsu_mac.sv
// ---------------------------------------------------------------------------
// otsu_mac
// Shared 32x32 multiplier with a limb-shifted 128-bit accumulator.
// A request is registered as a product, then added into the accumulator.
// ---------------------------------------------------------------------------
module otsu_mac (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  otsu_pkg::t_mac_op             i_op,
    output logic [otsu_pkg::ACC_W-1:0]    o_acc
);
    import otsu_pkg::*;

    logic [PROD_W-1:0] r_prod;
    logic [1:0]        r_sh;
    logic              r_clr;
    logic              r_en;
    logic [ACC_W-1:0]  r_acc;
    logic [ACC_W-1:0]  shifted;

    assign shifted = {{(ACC_W-PROD_W){1'b0}}, r_prod} << (LIMB_W * int'(r_sh));
    assign o_acc   = r_acc;

    always_ff @(posedge i_clk) begin
        r_prod <= i_op.a * i_op.b;
        r_sh   <= i_op.sh;
        r_clr  <= i_op.clr;
        if (r_en) begin
            r_acc <= (r_clr ? '0 : r_acc) + shifted;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en <= 1'b0;
        end else begin
            r_en <= i_op.en;
        end
    end

endmodule

### rtl/core/otsu_back.sv
// ---------------------------------------------------------------------------
// otsu_back
// Histogram store and threshold sweep. Fills the 256-bin histogram one pixel
// a cycle, then on the last pixel walks the levels, scoring each proper split
// with the shared multiplier, and puts the best level in the output register.
// ---------------------------------------------------------------------------
module otsu_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_q_vld,
    input  otsu_pkg::t_pix               i_q_item,
    output logic                         o_pop,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [otsu_pkg::LVL_W-1:0]   o_threshold
);
    import otsu_pkg::*;

    // steps of one level's scoring
    localparam logic [STEP_W-1:0] K_ISS_P = 5'd0;
    localparam logic [STEP_W-1:0] K_ISS_Q = 5'd1;
    localparam logic [STEP_W-1:0] K_ISS_W = 5'd2;
    localparam logic [STEP_W-1:0] K_GET_Q = 5'd3;
    localparam logic [STEP_W-1:0] K_GET_W = 5'd4;
    localparam logic [STEP_W-1:0] K_SQ_LL = 5'd5;
    localparam logic [STEP_W-1:0] K_SQ_LH = 5'd6;
    localparam logic [STEP_W-1:0] K_SQ_HL = 5'd7;
    localparam logic [STEP_W-1:0] K_SQ_HH = 5'd8;
    localparam logic [STEP_W-1:0] K_GET_S = 5'd10;
    localparam logic [STEP_W-1:0] K_LHS_0 = 5'd11;
    localparam logic [STEP_W-1:0] K_LHS_1 = 5'd12;
    localparam logic [STEP_W-1:0] K_LHS_2 = 5'd13;
    localparam logic [STEP_W-1:0] K_RHS_0 = 5'd15;
    localparam logic [STEP_W-1:0] K_RHS_1 = 5'd16;
    localparam logic [STEP_W-1:0] K_RHS_2 = 5'd17;
    localparam logic [STEP_W-1:0] K_CMP   = 5'd19;

    t_state r_state, n_state;

    // histogram memory and per-bin valid bits
    logic [CNT_W-1:0] r_mem [NBINS];
    logic [NBINS-1:0] r_bin_vld;
    logic [CNT_W-1:0] r_rd;
    logic             r_rd_bv;
    logic             rd_en;
    logic [LVL_W-1:0] rd_addr;

    // accumulate pipeline
    logic             r_p1_vld;
    logic             r_p1_last;
    logic [LVL_W-1:0] r_p1_g;
    logic             r_fwd_vld;
    logic [LVL_W-1:0] r_fwd_addr;
    logic [CNT_W-1:0] r_fwd_data;
    logic [CNT_W-1:0] cur_cnt;
    logic [CNT_W-1:0] new_cnt;
    logic [CNT_W-1:0] r_pix_cnt;
    logic [SUM_W-1:0] r_val_sum;

    // sweep
    logic [LVL_W-1:0]  r_t;
    logic [STEP_W-1:0] r_k;
    logic [WB_W-1:0]   r_wb;
    logic [SUM_W-1:0]  r_bs;
    logic [CNT_W-1:0]  h;
    logic [WB_W-1:0]   bin_wb;
    logic [LVL_W+CNT_W-1:0] th;
    logic [SUM_W-1:0]  bin_bs;
    logic [DIFF_W-1:0] r_p, r_q, r_d;
    logic [WT_W-1:0]   r_w;
    logic [SQ_W-1:0]   r_dsq;
    logic [ACC_W-1:0]  r_lhs;
    logic [SQ_W-1:0]   r_best_sq;
    logic [WT_W-1:0]   r_best_w;
    logic [LVL_W-1:0]  r_best_lvl;
    logic [CNT_W-1:0]  fg_cnt;
    logic              better;

    logic             r_out_vld;
    logic [LVL_W-1:0] r_out_thr;
    logic             out_free;

    t_mac_op          mac_op;
    logic [ACC_W-1:0] acc;

    otsu_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (mac_op),
        .o_acc   (acc)
    );

    assign o_valid     = r_out_vld;
    assign o_threshold = r_out_thr;
    assign out_free    = !r_out_vld || !i_stall;

    assign cur_cnt = (r_fwd_vld && (r_fwd_addr == r_p1_g)) ? r_fwd_data
                   : (r_rd_bv ? r_rd : '0);
    assign new_cnt = cur_cnt + CNT_W'(1);

    assign h      = r_rd_bv ? r_rd : '0;
    assign bin_wb = r_wb + WB_W'(h);
    assign th     = r_t * h;
    assign bin_bs = r_bs + th[SUM_W-1:0];
    assign fg_cnt = r_pix_cnt - r_wb[CNT_W-1:0];
    assign better = r_lhs > acc;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_ACCUM: begin
                if (r_p1_vld && r_p1_last) n_state = S_RD;
            end
            S_RD: begin
                n_state = S_BIN;
            end
            S_BIN: begin
                if (bin_wb == '0) begin
                    n_state = (r_t == LAST_LVL) ? S_EMIT : S_RD;
                end else if (bin_wb >= {1'b0, r_pix_cnt}) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_CALC;
                end
            end
            S_CALC: begin
                if (r_k == K_CMP) n_state = (r_t == LAST_LVL) ? S_EMIT : S_RD;
            end
            S_EMIT: begin
                if (out_free) n_state = S_ACCUM;
            end
            default: n_state = S_ACCUM;
        endcase
    end

    // control outputs
    always_comb begin
        o_pop   = 1'b0;
        rd_en   = 1'b0;
        rd_addr = r_t;
        mac_op  = '0;
        unique case (r_state)
            S_ACCUM: begin
                o_pop   = i_q_vld && !(r_p1_vld && r_p1_last);
                rd_en   = o_pop;
                rd_addr = i_q_item.green;
            end
            S_RD: begin
                rd_en = 1'b1;
            end
            S_CALC: begin
                case (r_k)
                    K_ISS_P: mac_op = '{1'b1, 1'b1, 2'd0,
                                        LIMB_W'(r_pix_cnt), LIMB_W'(r_bs)};
                    K_ISS_Q: mac_op = '{1'b1, 1'b1, 2'd0,
                                        LIMB_W'(r_val_sum), LIMB_W'(r_wb)};
                    K_ISS_W: mac_op = '{1'b1, 1'b1, 2'd0,
                                        LIMB_W'(r_wb[CNT_W-1:0]), LIMB_W'(fg_cnt)};
                    K_SQ_LL: mac_op = '{1'b1, 1'b1, 2'd0,
                                        r_d[LIMB_W-1:0], r_d[LIMB_W-1:0]};
                    K_SQ_LH: mac_op = '{1'b1, 1'b0, 2'd1, r_d[LIMB_W-1:0],
                                        LIMB_W'(r_d[DIFF_W-1:LIMB_W])};
                    K_SQ_HL: mac_op = '{1'b1, 1'b0, 2'd1,
                                        LIMB_W'(r_d[DIFF_W-1:LIMB_W]), r_d[LIMB_W-1:0]};
                    K_SQ_HH: mac_op = '{1'b1, 1'b0, 2'd2,
                                        LIMB_W'(r_d[DIFF_W-1:LIMB_W]),
                                        LIMB_W'(r_d[DIFF_W-1:LIMB_W])};
                    K_LHS_0: mac_op = '{1'b1, 1'b1, 2'd0, r_dsq[LIMB_W-1:0], r_best_w};
                    K_LHS_1: mac_op = '{1'b1, 1'b0, 2'd1,
                                        r_dsq[2*LIMB_W-1:LIMB_W], r_best_w};
                    K_LHS_2: mac_op = '{1'b1, 1'b0, 2'd2,
                                        LIMB_W'(r_dsq[SQ_W-1:2*LIMB_W]), r_best_w};
                    K_RHS_0: mac_op = '{1'b1, 1'b1, 2'd0, r_best_sq[LIMB_W-1:0], r_w};
                    K_RHS_1: mac_op = '{1'b1, 1'b0, 2'd1,
                                        r_best_sq[2*LIMB_W-1:LIMB_W], r_w};
                    K_RHS_2: mac_op = '{1'b1, 1'b0, 2'd2,
                                        LIMB_W'(r_best_sq[SQ_W-1:2*LIMB_W]), r_w};
                    default: mac_op = '0;
                endcase
            end
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    // histogram memory
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd    <= r_mem[rd_addr];
            r_rd_bv <= r_bin_vld[rd_addr];
        end
        if (r_p1_vld) begin
            r_mem[r_p1_g] <= new_cnt;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_p1_g    <= i_q_item.green;
            r_p1_last <= i_q_item.last;
        end
        if (r_p1_vld) begin
            r_fwd_addr <= r_p1_g;
            r_fwd_data <= new_cnt;
        end
        if (r_state == S_CALC) begin
            if (r_k == K_ISS_W) r_p <= acc[DIFF_W-1:0];
            if (r_k == K_GET_Q) r_q <= acc[DIFF_W-1:0];
            if (r_k == K_GET_W) begin
                r_w <= acc[WT_W-1:0];
                r_d <= (r_p >= r_q) ? (r_p - r_q) : (r_q - r_p);
            end
            if (r_k == K_GET_S) r_dsq <= acc[SQ_W-1:0];
            if (r_k == K_RHS_0) r_lhs <= acc;
        end
        if (r_state == S_EMIT && out_free) begin
            r_out_thr <= r_best_lvl;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_ACCUM;
            r_p1_vld   <= 1'b0;
            r_fwd_vld  <= 1'b0;
            r_bin_vld  <= '0;
            r_pix_cnt  <= '0;
            r_val_sum  <= '0;
            r_t        <= '0;
            r_k        <= '0;
            r_wb       <= '0;
            r_bs       <= '0;
            r_best_sq  <= '0;
            r_best_w   <= WT_W'(1);
            r_best_lvl <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_p1_vld <= o_pop;

            if (r_p1_vld) begin
                r_bin_vld[r_p1_g] <= 1'b1;
                r_fwd_vld         <= 1'b1;
                r_pix_cnt         <= r_pix_cnt + CNT_W'(1);
                r_val_sum         <= r_val_sum + SUM_W'(r_p1_g);
            end

            // frame complete: start the sweep
            if (r_state == S_ACCUM && r_p1_vld && r_p1_last) begin
                r_t        <= '0;
                r_wb       <= '0;
                r_bs       <= '0;
                r_best_sq  <= '0;
                r_best_w   <= WT_W'(1);
                r_best_lvl <= '0;
            end

            if (r_state == S_BIN) begin
                r_k <= '0;
                if (bin_wb == '0) begin
                    r_t <= r_t + LVL_W'(1);
                end else begin
                    r_wb <= bin_wb;
                    r_bs <= bin_bs;
                end
            end

            if (r_state == S_CALC) begin
                r_k <= r_k + STEP_W'(1);
                if (r_k == K_CMP) begin
                    r_t <= r_t + LVL_W'(1);
                    if (better) begin
                        r_best_sq  <= r_dsq;
                        r_best_w   <= r_w;
                        r_best_lvl <= r_t;
                    end
                end
            end

            if (r_state == S_EMIT && out_free) begin
                r_out_vld <= 1'b1;
                r_bin_vld <= '0;
                r_fwd_vld <= 1'b0;
                r_pix_cnt <= '0;
                r_val_sum <= '0;
            end else if (r_out_vld && !i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    property p_step_bound;
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CALC) |-> (r_k <= K_CMP);
    endproperty
    a_step_bound: assert property (p_step_bound)
        else $error("scoring step past compare");

    property p_sweep_start;
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACCUM && r_p1_vld && r_p1_last)
            |=> (r_state == S_RD && r_t == '0 && !r_p1_vld);
    endproperty
    a_sweep_start: assert property (p_sweep_start)
        else $error("sweep did not start cleanly after last pixel");

    property p_emit_clear;
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && out_free)
            |=> (r_state == S_ACCUM && r_out_vld && r_pix_cnt == '0 && r_bin_vld == '0);
    endproperty
    a_emit_clear: assert property (p_emit_clear)
        else $error("frame state not cleared on emit");

    property p_wb_below_n;
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CALC) |-> (r_wb < {1'b0, r_pix_cnt} && r_wb != '0);
    endproperty
    a_wb_below_n: assert property (p_wb_below_n)
        else $error("scoring a level with an empty class");

endmodule

### rtl/core/otsu_threshold_from_histogram_core.sv
// ---------------------------------------------------------------------------
// otsu_threshold_from_histogram_core
// Per-frame Otsu threshold from the green values of a pixel stream.
// ---------------------------------------------------------------------------
// Pixels are taken at one per cycle into a 256-bin histogram. The pixel with
// frame_end set starts the threshold sweep, during which no pixel is taken
// (two more fit in the intake queue). An empty level is read and skipped; a
// level with two non-empty classes is read and then scored on the single
// shared 32x32 multiplier, which handles thirteen partial products per level.
// The threshold goes out in one transfer per frame and the histogram is clear
// for the next frame at once.
// ---------------------------------------------------------------------------
module otsu_threshold_from_histogram_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [otsu_pkg::LVL_W-1:0]   i_green_value,
    input  logic                         i_frame_end,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [otsu_pkg::LVL_W-1:0]   o_threshold
);
    import otsu_pkg::*;

    logic q_vld;
    t_pix q_item;
    logic pop;

    otsu_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_green_value (i_green_value),
        .i_frame_end   (i_frame_end),
        .o_q_vld       (q_vld),
        .o_q_item      (q_item),
        .i_pop         (pop)
    );

    otsu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_vld     (q_vld),
        .i_q_item    (q_item),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_threshold (o_threshold)
    );

endmodule

### tb/sv/otsu_threshold_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// otsu_threshold_checker
// Watches the pixel and threshold channels, predicts the frame threshold and
// compares every threshold transfer against the oldest prediction.
// ---------------------------------------------------------------------------
module otsu_threshold_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic                       o_stall,
    input  logic [otsu_pkg::LVL_W-1:0] i_green_value,
    input  logic                       i_frame_end,
    input  logic                       o_valid,
    input  logic                       i_stall,
    input  logic [otsu_pkg::LVL_W-1:0] o_threshold,
    output int                         fail_count,
    output int                         thresholds_pending
);
    import otsu_pkg::*;

    logic [CNT_W-1:0] hist [NBINS];
    logic [CNT_W-1:0] frame_pixels;
    logic [SUM_W-1:0] frame_sum;
    logic [LVL_W-1:0] expected_thresholds [$];

    // exact Otsu sweep: compare d^2/w fractions by cross-multiplying
    function automatic logic [LVL_W-1:0] otsu_level();
        longint unsigned n, wb, h, p, q;
        logic [SUM_W-1:0]  sum_below;
        logic [DIFF_W-1:0] d, top_d;
        logic [WT_W-1:0]   w, top_w;
        logic [127:0]      lhs, rhs;
        logic [LVL_W-1:0]  top_lvl;
        n = frame_pixels;
        wb = 0;
        sum_below = '0;
        top_d = '0;
        top_w = 1;
        top_lvl = '0;
        for (int t = 0; t < NBINS; t++) begin
            h = hist[t];
            wb += h;
            if (wb == 0) continue;
            if (wb >= n) break;
            sum_below = SUM_W'(sum_below + t * h);
            p = n * sum_below;
            q = longint'(frame_sum) * wb;
            d = DIFF_W'(p >= q ? p - q : q - p);
            w = WT_W'(wb * (n - wb));
            lhs = 128'(d) * 128'(d) * 128'(top_w);
            rhs = 128'(top_d) * 128'(top_d) * 128'(w);
            if (lhs > rhs) begin
                top_d = d;
                top_w = w;
                top_lvl = LVL_W'(t);
            end
        end
        return top_lvl;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (hist[k]) hist[k] = '0;
            frame_pixels = '0;
            frame_sum = '0;
            expected_thresholds.delete();
            fail_count = 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_thresholds.size() == 0) begin
                    $display("%0t: threshold transfer with nothing expected, actual %0d",
                             $time, o_threshold);
                    fail_count++;
                end else begin
                    logic [LVL_W-1:0] want;
                    want = expected_thresholds.pop_front();
                    if (o_threshold !== want) begin
                        $display("%0t: threshold mismatch, expected %0d actual %0d",
                                 $time, want, o_threshold);
                        fail_count++;
                    end
                end
            end
            if (i_valid && !o_stall) begin
                hist[i_green_value] = hist[i_green_value] + 1'b1;
                frame_pixels = frame_pixels + 1'b1;
                frame_sum = frame_sum + i_green_value;
                if (i_frame_end) begin
                    expected_thresholds.push_back(otsu_level());
                    foreach (hist[k]) hist[k] = '0;
                    frame_pixels = '0;
                    frame_sum = '0;
                end
            end
        end
        thresholds_pending = expected_thresholds.size();
    end

endmodule

### tb/sv/otsu_threshold_from_histogram_core_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// otsu_threshold_from_histogram_core_tb
// Sends directed and random frames of green values with random idling on
// both channels; a side checker predicts and compares each threshold.
// ---------------------------------------------------------------------------
module otsu_threshold_from_histogram_core_tb;
    import otsu_pkg::*;

    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int PIXEL_GOAL  = 400;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_valid = 1'b0;
    logic             o_stall;
    logic [LVL_W-1:0] i_green_value = '0;
    logic             i_frame_end = 1'b0;
    logic             o_valid;
    logic             i_stall = 1'b0;
    logic [LVL_W-1:0] o_threshold;
    int               fail_count;
    int               thresholds_pending;
    int               cycles = 0;
    int               pixels_sent = 0;
    bit               quiet = 1'b0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    otsu_threshold_from_histogram_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_green_value (i_green_value),
        .i_frame_end   (i_frame_end),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_threshold   (o_threshold)
    );

    otsu_threshold_checker u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_green_value      (i_green_value),
        .i_frame_end        (i_frame_end),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_threshold        (o_threshold),
        .fail_count         (fail_count),
        .thresholds_pending (thresholds_pending)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // receiver stall bursts
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall <= 1'b1;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 14);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    task automatic send_pixel(input logic [LVL_W-1:0] g, input logic last);
        int gap;
        if (!quiet && $urandom_range(0, 9) == 0) begin
            gap = $urandom_range(1, 15);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_green_value <= g;
        i_frame_end <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pixels_sent++;
    endtask

    task automatic send_frame(input int len, input int shape);
        logic [LVL_W-1:0] g, lo, hi;
        lo = LVL_W'($urandom);
        hi = LVL_W'($urandom);
        for (int k = 0; k < len; k++) begin
            case (shape)
                0: g = LVL_W'($urandom);
                1: g = $urandom_range(0, 1) ? lo : hi;
                2: g = LVL_W'((($urandom_range(0, 1) ? lo : hi) + $urandom_range(0, 6)));
                3: g = lo;
                default: g = $urandom_range(0, 1) ? '0 : LAST_LVL;
            endcase
            send_pixel(g, k == len - 1);
        end
    endtask

    initial begin
        int len;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single pixel frames, extremes, ties and a flat frame
        send_pixel('0, 1'b1);
        send_pixel(LAST_LVL, 1'b1);
        send_pixel('0, 1'b0);
        send_pixel(LAST_LVL, 1'b1);
        send_pixel(8'd7, 1'b0);
        send_pixel(8'd7, 1'b0);
        send_pixel(8'd7, 1'b1);
        send_pixel('0, 1'b0);
        send_pixel(LAST_LVL, 1'b0);
        send_pixel('0, 1'b0);
        send_pixel(LAST_LVL, 1'b0);
        send_pixel(8'd128, 1'b1);
        for (int b = 0; b < LVL_W; b++) send_pixel(LVL_W'(1 << b), 1'b0);
        send_pixel(8'h55, 1'b0);
        send_pixel(8'hAA, 1'b1);

        while (pixels_sent < PIXEL_GOAL) begin
            if (pixels_sent > PIXEL_GOAL - 60) quiet = 1'b1;
            if ($urandom_range(0, 15) == 0)
                len = $urandom_range(100, 300);
            else
                len = $urandom_range(1, 30);
            if (len > PIXEL_GOAL - pixels_sent) len = PIXEL_GOAL - pixels_sent;
            send_frame(len, $urandom_range(0, 4));
        end
        i_valid <= 1'b0;
        i_frame_end <= 1'b0;

        // let the checker see the last transfer first
        @(posedge i_clk);
        while (thresholds_pending != 0) @(posedge i_clk);
        repeat (32) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
